// ===== hw/rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key-value cache
// Sizes, codes and the scan result word passed from the compare unit to the
// sequencer.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;

  // what one pass over the entries found
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    idx_t  hit_rank;
    data_t hit_value;
    logic  free_found;
    idx_t  free_idx;
    logic  lru_found;
    idx_t  lru_idx;
    idx_t  lru_rank;
  } scan_res_t;

endpackage

// ===== hw/rtl/lkv_kv_ram.sv =====
// ----------------------------------------------------------------------------
// lkv_kv_ram: key and value storage
// One write port and one read port with registered read data; each word holds
// a key in the upper half and its value in the lower half.
// ----------------------------------------------------------------------------
module lkv_kv_ram
  import lkv_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  idx_t                waddr,
  input  logic [2*DATA_W-1:0] wdata,
  input  logic                re,
  input  idx_t                raddr,
  output logic [2*DATA_W-1:0] rdata
);

  logic [2*DATA_W-1:0] mem [ENTRIES];

  // write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read one word, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lkv_scan.sv =====
// ----------------------------------------------------------------------------
// lkv_scan: shared key compare and rank search unit
// Takes one entry per cycle and keeps the running hit, the lowest free entry
// and the least recent valid entry seen so far.
// ----------------------------------------------------------------------------
module lkv_scan
  import lkv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  data_t     probe_key,
  input  logic      samp_en,
  input  idx_t      samp_idx,
  input  logic      samp_valid,
  input  idx_t      samp_rank,
  input  data_t     samp_key,
  input  data_t     samp_value,
  output scan_res_t res
);

  // accumulate over the sample stream, restart on clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res <= '0;
    end else if (samp_en) begin
      if (samp_valid && (samp_key == probe_key)) begin
        res.hit       <= 1'b1;
        res.hit_idx   <= samp_idx;
        res.hit_rank  <= samp_rank;
        res.hit_value <= samp_value;
      end
      if (!samp_valid && !res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= samp_idx;
      end
      if (samp_valid && (!res.lru_found || (samp_rank > res.lru_rank))) begin
        res.lru_found <= 1'b1;
        res.lru_idx   <= samp_idx;
        res.lru_rank  <= samp_rank;
      end
    end
  end

endmodule

// ===== hw/rtl/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key-value cache with LRU reuse
// Each accepted word is a get or a put; exactly one result word follows,
// marked by done for a single cycle, and it cannot be held off. A new
// word is accepted only once the previous one has been written back: the
// key comparator visits the sixteen entries one per cycle through the
// storage read port, the read register is drained, and then value and
// recency ranks are written back while the result is registered.
// busy is high from accept until the result is presented. The store starts
// empty after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
  import lkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CAP_W-1:0]   cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               done,
  output logic               found,
  output logic signed [31:0] read_value,
  output logic               evicted
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic                req_action;
  data_t               req_key;
  data_t               req_value;
  logic [CAP_W-1:0]    cap;
  logic [ENTRIES-1:0]  valid;
  idx_t                rank [ENTRIES];
  logic [CNT_W-1:0]    count;
  logic                samp_en;
  idx_t                samp_idx;
  logic                rd_en;
  logic [2*DATA_W-1:0] rd_data;
  scan_res_t           res;
  logic                accept;
  logic                scan_last;

  // update decisions
  logic  touch_en;
  idx_t  touch_idx;
  idx_t  touch_rank;
  logic  fill_en;
  logic  wr_en;
  idx_t  wr_idx;
  logic  res_found;
  data_t res_value;
  logic  res_evict;
  logic  room;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign scan_last = (cnt == CNT_W'(ENTRIES));
  assign rd_en     = (state == S_SCAN) && !scan_last;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_write) begin
      cap <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (scan_last) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // hold the request word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
      req_value  <= value;
    end
  end

  // align the sample with the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      samp_en <= 1'b0;
    end else begin
      samp_en <= rd_en;
    end
    samp_idx <= cnt[IDX_W-1:0];
  end

  lkv_kv_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata ({req_key, req_value}),
    .re    (rd_en),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  lkv_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .probe_key  (req_key),
    .samp_en    (samp_en),
    .samp_idx   (samp_idx),
    .samp_valid (valid[samp_idx]),
    .samp_rank  (rank[samp_idx]),
    .samp_key   (rd_data[2*DATA_W-1:DATA_W]),
    .samp_value (rd_data[DATA_W-1:0]),
    .res        (res)
  );

  // fill allowed while count is below the capacity, a zero capacity acting as one
  assign room = (32'(count) < 32'(cap)) || ((cap == '0) && (count == '0));

  // decide the outcome of the item from the scan result
  always_comb begin
    touch_en   = 1'b0;
    touch_idx  = res.hit_idx;
    touch_rank = res.hit_rank;
    fill_en    = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = res.hit_idx;
    res_found  = res.hit;
    res_value  = '0;
    res_evict  = 1'b0;
    if (state == S_UPDATE) begin
      if (req_action == ACT_GET) begin
        if (res.hit) begin
          res_value = res.hit_value;
          touch_en  = 1'b1;
        end else begin
          res_value = MISS_VALUE;
        end
      end else if (res.hit) begin
        wr_en    = 1'b1;
        touch_en = 1'b1;
      end else if (room && res.free_found) begin
        fill_en = 1'b1;
        wr_en   = 1'b1;
        wr_idx  = res.free_idx;
      end else if (res.lru_found) begin
        touch_en   = 1'b1;
        touch_idx  = res.lru_idx;
        touch_rank = res.lru_rank;
        wr_en      = 1'b1;
        wr_idx     = res.lru_idx;
        res_evict  = 1'b1;
      end
    end
  end

  // age ranks, mark the filled entry valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch_en) begin
          if (IDX_W'(i) == touch_idx) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < touch_rank)) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end else if (fill_en) begin
          if (IDX_W'(i) == res.free_idx) begin
            rank[i]  <= '0;
            valid[i] <= 1'b1;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + IDX_W'(1);
          end
        end
      end
      if (fill_en) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // present the result word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_UPDATE);
    end
    if (state == S_UPDATE) begin
      found      <= res_found;
      read_value <= res_value;
      evicted    <= res_evict;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without a writeback cycle");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count differs from the number of valid entries");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !found)
    else $error("eviction reported for a key that was present");

  a_no_fill_and_touch: assert property (@(posedge clk) disable iff (rst)
    !(fill_en && touch_en))
    else $error("fill and recency touch in the same writeback");

  a_busy_through_item: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
`endif

endmodule
